// ===== hw/rtl/orbuf_pkg.sv =====
// ----------------------------------------------------------------------------
// orbuf_pkg
// Shared types, codes and defaults for the overwriting sample ring buffer.
// ----------------------------------------------------------------------------
package orbuf_pkg;

    localparam int unsigned DEPTH_DEFAULT      = 64;
    localparam int unsigned JOB_QUEUE_DEPTH    = 2;
    localparam int unsigned RESULT_QUEUE_DEPTH = 4;

    // command codes
    localparam logic [2:0] CMD_WRITE   = 3'd0;
    localparam logic [2:0] CMD_SILENCE = 3'd1;
    localparam logic [2:0] CMD_CONSUME = 3'd2;
    localparam logic [2:0] CMD_WINDOW  = 3'd3;
    localparam logic [2:0] CMD_DRAIN   = 3'd4;
    localparam logic [2:0] CMD_LATEST  = 3'd5;

    // status codes
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_REFUSED = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] sample_in;
        logic [15:0] count;
        logic [63:0] mark;
    } item_t;

    typedef struct packed {
        logic        sample_valid;
        logic [31:0] sample_out;
        logic        last;
        logic [1:0]  status;
        logic        overrun;
        logic [6:0]  returned_count;
        logic [6:0]  available_to_read;
        logic [6:0]  available_to_write;
        logic [63:0] total_written;
    } result_t;

    // what the back end does with a classified transaction
    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_READ,
        JOB_NOTE
    } job_op_t;

    typedef struct packed {
        job_op_t     op;
        logic [31:0] wdata;
        logic [1:0]  status;
        logic        overrun;
        logic [6:0]  returned_count;
        logic [6:0]  available_to_read;
        logic [6:0]  available_to_write;
        logic [63:0] total_written;
    } job_info_t;

endpackage

// ===== hw/rtl/orbuf_ram.sv =====
// ----------------------------------------------------------------------------
// orbuf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module orbuf_ram #(
    parameter int unsigned WIDTH   = 32,
    parameter int unsigned ENTRIES = 64,
    localparam int unsigned AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [ENTRIES];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/orbuf_queue.sv =====
// ----------------------------------------------------------------------------
// orbuf_queue
// Small register FIFO; caller never pushes when full nor pops when empty.
// ----------------------------------------------------------------------------
module orbuf_queue #(
    parameter int unsigned WIDTH   = 8,
    parameter int unsigned ENTRIES = 2,
    localparam int unsigned PW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int unsigned LVW    = $clog2(ENTRIES + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty,
    output logic [LVW-1:0]   level
);

    logic [WIDTH-1:0] store_reg [ENTRIES];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LVW-1:0]   level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(ENTRIES - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(ENTRIES - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            level_next = level_reg + LVW'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - LVW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = store_reg[rd_ptr_reg];
    assign full     = (level_reg == LVW'(ENTRIES));
    assign empty    = (level_reg == '0);
    assign level    = level_reg;

endmodule

// ===== hw/rtl/orbuf_front.sv =====
// ----------------------------------------------------------------------------
// orbuf_front
// Registers a transaction, classifies it and keeps positions and occupancy.
// ----------------------------------------------------------------------------
module orbuf_front import orbuf_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEFAULT,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned LW   = $clog2(DEPTH + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  item_t           item,
    output logic            job_push,
    input  logic            job_full,
    output job_info_t       job_info,
    output logic [AW-1:0]   job_addr,
    output logic [LW-1:0]   job_len
);

    // occupancy saturates at DEPTH+1: only the DEPTH threshold matters
    localparam int unsigned OW = $clog2(DEPTH + 2);
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);
    localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);
    localparam logic [OW-1:0] OCC_CAP = OW'(DEPTH + 1);

    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a,
                                               input logic [LW-1:0] b);
        logic [LW:0] s;
        s = (LW+1)'(a) + (LW+1)'(b);
        if (s >= (LW+1)'(DEPTH))
        begin
            s = s - (LW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [OW-1:0] occ_add(input logic [OW-1:0] o,
                                              input logic [LW-1:0] k);
        logic [OW:0] s;
        s = (OW+1)'(o) + (OW+1)'(k);
        return (s > (OW+1)'(DEPTH + 1)) ? OCC_CAP : s[OW-1:0];
    endfunction

    logic          item_valid_reg;
    item_t         item_reg;
    logic [63:0]   wpos_reg, wpos_next;
    logic [AW-1:0] wslot_reg, wslot_next;
    logic [AW-1:0] rslot_reg, rslot_next;
    logic [OW-1:0] occ_reg, occ_next;

    logic [15:0]   cnt;
    logic          cnt_big;
    logic [LW-1:0] cnt_clamp;
    logic [63:0]   win_end;
    logic [64:0]   win_diff;
    logic [LW-1:0] win_room;
    logic [LW-1:0] win_back;
    logic          win_refuse;
    logic [AW-1:0] win_start;
    logic          ovr;
    logic [LW-1:0] occ_clip;
    logic [AW-1:0] rslot_sync;
    logic [LW-1:0] take;

    assign job_push   = item_valid_reg && !job_full;
    assign item_stall = item_valid_reg && job_full;

    // operands
    always_comb
    begin
        cnt       = item_reg.count;
        cnt_big   = cnt > 16'(DEPTH);
        cnt_clamp = cnt_big ? DEPTH_L : cnt[LW-1:0];

        win_end    = (item_reg.command == CMD_LATEST) ? wpos_reg : item_reg.mark;
        win_diff   = {1'b0, wpos_reg} - {1'b0, win_end};
        win_room   = DEPTH_L - cnt_clamp;
        win_refuse = (cnt == '0) || cnt_big || (win_end < 64'(cnt)) || win_diff[64]
                     || (win_diff[63:0] > 64'(win_room));
        // distance back from the write slot to the window's first sample
        win_back   = win_diff[LW-1:0] + cnt_clamp;
        win_start  = slot_add(wslot_reg, DEPTH_L - win_back);

        ovr        = occ_reg > DEPTH_O;
        occ_clip   = ovr ? DEPTH_L : occ_reg[LW-1:0];
        rslot_sync = ovr ? wslot_reg : rslot_reg;
        take       = (cnt > 16'(occ_clip)) ? occ_clip : cnt[LW-1:0];
    end

    // classification
    always_comb
    begin
        wpos_next  = wpos_reg;
        wslot_next = wslot_reg;
        rslot_next = rslot_reg;
        occ_next   = occ_reg;

        job_info                = '0;
        job_info.op             = JOB_NOTE;
        job_info.status         = STATUS_DONE;
        job_addr                = '0;
        job_len                 = '0;

        unique case (item_reg.command)
            CMD_WRITE:
            begin
                job_info.op    = JOB_WRITE;
                job_info.wdata = item_reg.sample_in;
                job_addr       = wslot_reg;
                job_len        = LW'(1);
                wpos_next      = wpos_reg + 64'd1;
                wslot_next     = slot_add(wslot_reg, LW'(1));
                occ_next       = occ_add(occ_reg, LW'(1));
            end
            CMD_SILENCE:
            begin
                job_info.op = JOB_WRITE;
                job_addr    = wslot_reg;
                job_len     = cnt_clamp;
                wpos_next   = wpos_reg + 64'(cnt_clamp);
                wslot_next  = slot_add(wslot_reg, cnt_clamp);
                occ_next    = occ_add(occ_reg, cnt_clamp);
            end
            CMD_CONSUME:
            begin
                if (cnt != '0)
                begin
                    job_info.overrun = ovr;
                    if (take == '0)
                    begin
                        job_info.status = STATUS_EMPTY;
                        rslot_next      = rslot_sync;
                        occ_next        = OW'(occ_clip);
                    end
                    else
                    begin
                        job_info.op             = JOB_READ;
                        job_info.returned_count = 7'(take);
                        job_addr                = rslot_sync;
                        job_len                 = take;
                        rslot_next              = slot_add(rslot_sync, take);
                        occ_next                = OW'(occ_clip - take);
                    end
                end
            end
            CMD_WINDOW, CMD_LATEST:
            begin
                if (win_refuse)
                begin
                    job_info.status = STATUS_REFUSED;
                end
                else
                begin
                    job_info.op             = JOB_READ;
                    job_info.returned_count = 7'(cnt);
                    job_addr                = win_start;
                    job_len                 = cnt_clamp;
                end
            end
            CMD_DRAIN:
            begin
                occ_next   = '0;
                rslot_next = wslot_reg;
            end
            default:
            begin
            end
        endcase

        job_info.available_to_read  = 7'((occ_next > DEPTH_O) ? DEPTH_O : occ_next);
        job_info.available_to_write = 7'((occ_next >= DEPTH_O) ? '0 : DEPTH_O - occ_next);
        job_info.total_written      = wpos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            wpos_reg       <= '0;
            wslot_reg      <= '0;
            rslot_reg      <= '0;
            occ_reg        <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (job_push)
            begin
                item_valid_reg <= 1'b0;
            end
            if (job_push)
            begin
                wpos_reg  <= wpos_next;
                wslot_reg <= wslot_next;
                rslot_reg <= rslot_next;
                occ_reg   <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

endmodule

// ===== hw/rtl/orbuf_back.sv =====
// ----------------------------------------------------------------------------
// orbuf_back
// Carries out jobs in order: store writes, store read runs, status results.
// ----------------------------------------------------------------------------
module orbuf_back import orbuf_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEFAULT,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned LW   = $clog2(DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_pop,
    input  job_info_t     job_info,
    input  logic [AW-1:0] job_addr,
    input  logic [LW-1:0] job_len,
    output logic          result_valid,
    input  logic          result_stall,
    output result_t       result
);

    localparam int unsigned RLW = $clog2(RESULT_QUEUE_DEPTH + 1);

    logic          cur_valid_reg, cur_valid_next;
    job_info_t     cur_info_reg, cur_info_next;
    logic [AW-1:0] cur_addr_reg, cur_addr_next;
    logic [LW-1:0] cur_rem_reg, cur_rem_next;
    logic          pend_valid_reg, pend_valid_next;
    result_t       pend_reg, pend_next;

    logic          space;
    logic          done;
    logic          advance;
    logic          ram_we;
    logic          ram_re;
    logic [31:0]   ram_rdata;
    result_t       res_push_data;
    logic [$bits(result_t)-1:0] res_pop_data;
    logic          res_full;
    logic          res_empty;
    logic [RLW-1:0] res_level;

    // room for one more result, counting the one in flight from the store
    assign space = (RLW'(res_level) + RLW'(pend_valid_reg)) < RLW'(RESULT_QUEUE_DEPTH);

    always_comb
    begin
        done            = 1'b0;
        advance         = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        pend_valid_next = 1'b0;

        pend_next                    = '0;
        pend_next.last               = 1'b1;
        pend_next.status             = cur_info_reg.status;
        pend_next.overrun            = cur_info_reg.overrun;
        pend_next.returned_count     = cur_info_reg.returned_count;
        pend_next.available_to_read  = cur_info_reg.available_to_read;
        pend_next.available_to_write = cur_info_reg.available_to_write;
        pend_next.total_written      = cur_info_reg.total_written;

        if (cur_valid_reg)
        begin
            unique case (cur_info_reg.op)
                JOB_WRITE:
                begin
                    if (cur_rem_reg > LW'(1))
                    begin
                        ram_we  = 1'b1;
                        advance = 1'b1;
                    end
                    else if (space)
                    begin
                        // last write goes out with the status result
                        ram_we          = (cur_rem_reg == LW'(1));
                        pend_valid_next = 1'b1;
                        done            = 1'b1;
                    end
                end
                JOB_READ:
                begin
                    if (space)
                    begin
                        ram_re                 = 1'b1;
                        advance                = 1'b1;
                        pend_valid_next        = 1'b1;
                        pend_next.sample_valid = 1'b1;
                        pend_next.last         = (cur_rem_reg == LW'(1));
                        done                   = (cur_rem_reg == LW'(1));
                    end
                end
                JOB_NOTE:
                begin
                    if (space)
                    begin
                        pend_valid_next = 1'b1;
                        done            = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end

        job_pop        = (!cur_valid_reg || done) && job_valid;
        cur_valid_next = cur_valid_reg;
        cur_info_next  = cur_info_reg;
        cur_addr_next  = cur_addr_reg;
        cur_rem_next   = cur_rem_reg;
        if (advance)
        begin
            cur_addr_next = (cur_addr_reg == AW'(DEPTH - 1)) ? '0 : cur_addr_reg + AW'(1);
            cur_rem_next  = cur_rem_reg - LW'(1);
        end
        if (!cur_valid_reg || done)
        begin
            cur_valid_next = job_valid;
            cur_info_next  = job_info;
            cur_addr_next  = job_addr;
            cur_rem_next   = job_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg  <= cur_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_info_reg <= cur_info_next;
        cur_addr_reg <= cur_addr_next;
        cur_rem_reg  <= cur_rem_next;
        pend_reg     <= pend_next;
    end

    orbuf_ram #(
        .WIDTH   (32),
        .ENTRIES (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_addr_reg),
        .wdata (cur_info_reg.wdata),
        .re    (ram_re),
        .raddr (cur_addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        res_push_data            = pend_reg;
        res_push_data.sample_out = pend_reg.sample_valid ? ram_rdata : '0;
    end

    orbuf_queue #(
        .WIDTH   ($bits(result_t)),
        .ENTRIES (RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pend_valid_reg),
        .push_data (res_push_data),
        .pop       (result_valid && !result_stall),
        .pop_data  (res_pop_data),
        .full      (res_full),
        .empty     (res_empty),
        .level     (res_level)
    );

    assign result_valid = !res_empty && !(res_full && 1'b0);
    assign result       = result_t'(res_pop_data);

endmodule

// ===== hw/rtl/overwriting_sample_ring_buffer_core.sv =====
// ----------------------------------------------------------------------------
// overwriting_sample_ring_buffer_core
// Overwriting circular store of 32-bit samples with 64-bit running positions;
// sample and silence writes, consume with overrun resync, window reads, drain.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake               payload
//   item      in    item_valid/item_stall     item_t   (command, sample, count, mark)
//   result    out   result_valid/result_stall result_t (sample, status, levels)
//
// Timing: the back end makes one store access at a time. Silence of k samples
// writes k slots and a read of n samples reads n slots, one sample per cycle off
// the store's read port while the result queue has room. A transaction passes
// the item register, the job queue, the back end's current job and the pending
// result register into the result queue before its first result is presented.
// Reset clears positions and occupancy at once; store contents are undefined
// until written and only written slots are ever read, so no clearing pass.
// Front and back are parted by a 2-deep job queue, results by a 4-deep queue,
// so a stalled result side still lets the front take transactions until full.
// ----------------------------------------------------------------------------
module overwriting_sample_ring_buffer_core import orbuf_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LW = $clog2(DEPTH + 1);
    localparam int unsigned JW = $bits(job_info_t) + AW + LW;

    // front -> job queue
    logic          fr_push;
    job_info_t     fr_info;
    logic [AW-1:0] fr_addr;
    logic [LW-1:0] fr_len;
    logic          jq_full;
    logic          jq_empty;
    logic [JW-1:0] jq_pop_data;

    // job queue -> back
    logic          bk_pop;
    job_info_t     bk_info;
    logic [AW-1:0] bk_addr;
    logic [LW-1:0] bk_len;

    orbuf_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .job_push   (fr_push),
        .job_full   (jq_full),
        .job_info   (fr_info),
        .job_addr   (fr_addr),
        .job_len    (fr_len)
    );

    orbuf_queue #(
        .WIDTH   (JW),
        .ENTRIES (JOB_QUEUE_DEPTH)
    ) u_job_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fr_push),
        .push_data ({fr_info, fr_addr, fr_len}),
        .pop       (bk_pop),
        .pop_data  (jq_pop_data),
        .full      (jq_full),
        .empty     (jq_empty),
        .level     ()
    );

    assign {bk_info, bk_addr, bk_len} = jq_pop_data;

    orbuf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (!jq_empty),
        .job_pop      (bk_pop),
        .job_info     (bk_info),
        .job_addr     (bk_addr),
        .job_len      (bk_len),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
